/* rtl/core/sqch_pkg.sv */
// ----------------------------------------------------------------------------
// sqch_pkg
// Shared types, constants and helper functions of the square-wave channel.
// ----------------------------------------------------------------------------
package sqch_pkg;

	localparam int SWEEP_UNIT_CYCLES    = 65536;
	localparam int LENGTH_UNIT_CYCLES   = 32768;
	localparam int ENVELOPE_UNIT_CYCLES = 131072;

	localparam int CYC_W  = 7;
	localparam int FREQ_W = 11;

	// signed counters: largest period plus one sign bit
	localparam int SWEEP_CNT_W = $clog2(7 * SWEEP_UNIT_CYCLES + 1) + 1;
	localparam int ENV_CNT_W   = $clog2(7 * ENVELOPE_UNIT_CYCLES + 1) + 1;
	localparam int LEN_CNT_W   = $clog2(64 * LENGTH_UNIT_CYCLES + 1) + 1;
	localparam int RELOAD_W    = 15;
	localparam int PER_CNT_W   = RELOAD_W + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// high steps of each duty pattern, bit i = duty position i
	localparam logic [3:0][7:0] DUTY_MASKS = {8'h7E, 8'hE1, 8'h81, 8'h80};

	typedef struct packed {
		logic load_in;
		logic do_write;
		logic sweep_dec;
		logic sweep_step;
		logic env_dec;
		logic env_step;
		logic len_dec;
		logic per_dec;
		logic per_step;
		logic out_load;
	} sqch_cmd_t;

	typedef struct packed {
		logic running;
		logic sweep_active;
		logic sweep_wrap;
		logic sweep_ovf;
		logic env_active;
		logic env_wrap;
		logic len_en;
		logic len_expire;
		logic per_wrap;
		logic out_free;
	} sqch_stat_t;

	function automatic logic [SWEEP_CNT_W-1:0] sweep_period(input logic [2:0] code);
		sweep_period = SWEEP_CNT_W'(code) * SWEEP_CNT_W'(SWEEP_UNIT_CYCLES);
	endfunction

	function automatic logic [ENV_CNT_W-1:0] env_period(input logic [2:0] code);
		env_period = ENV_CNT_W'(code) * ENV_CNT_W'(ENVELOPE_UNIT_CYCLES);
	endfunction

	function automatic logic [LEN_CNT_W-1:0] length_period(input logic [5:0] load);
		length_period = LEN_CNT_W'(7'd64 - {1'b0, load}) * LEN_CNT_W'(LENGTH_UNIT_CYCLES);
	endfunction

	// 8 * (2048 - frequency)
	function automatic logic [RELOAD_W-1:0] period_reload(input logic [FREQ_W-1:0] freq);
		logic [11:0] diff;
		diff = 12'd2048 - {1'b0, freq};
		period_reload = {diff, 3'b000};
	endfunction

	function automatic logic duty_high(input logic [1:0] sel, input logic [2:0] pos);
		duty_high = DUTY_MASKS[sel][pos];
	endfunction

endpackage

/* rtl/core/sqch_ctrl.sv */
// ----------------------------------------------------------------------------
// sqch_ctrl
// Sequencer of the square-wave channel: walks one item through write or
// sweep, envelope, length and duty steps, then hands the result out.
// ----------------------------------------------------------------------------
module sqch_ctrl import sqch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_tuser,
	input  sqch_stat_t stat,
	output sqch_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_WRITE    = 4'd1;
	localparam logic [3:0] ST_SW_DEC   = 4'd2;
	localparam logic [3:0] ST_SW_WRAP  = 4'd3;
	localparam logic [3:0] ST_ENV_DEC  = 4'd4;
	localparam logic [3:0] ST_ENV_WRAP = 4'd5;
	localparam logic [3:0] ST_LEN      = 4'd6;
	localparam logic [3:0] ST_PER_DEC  = 4'd7;
	localparam logic [3:0] ST_PER_WRAP = 4'd8;
	localparam logic [3:0] ST_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					if (s_tuser == OP_WRITE)
						state_d = ST_WRITE;
					else if (stat.running)
						state_d = ST_SW_DEC;
					else
						state_d = ST_DONE;
				end
			end
			ST_WRITE: begin
				cmd.do_write = 1'b1;
				state_d      = ST_DONE;
			end
			ST_SW_DEC: begin
				if (stat.sweep_active) begin
					cmd.sweep_dec = 1'b1;
					state_d       = ST_SW_WRAP;
				end else begin
					state_d = ST_ENV_DEC;
				end
			end
			ST_SW_WRAP: begin
				state_d = ST_ENV_DEC;
				if (stat.sweep_wrap) begin
					cmd.sweep_step = 1'b1;
					// overflow stops the channel and ends the tick
					if (stat.sweep_ovf)
						state_d = ST_DONE;
				end
			end
			ST_ENV_DEC: begin
				if (stat.env_active) begin
					cmd.env_dec = 1'b1;
					state_d     = ST_ENV_WRAP;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_ENV_WRAP: begin
				cmd.env_step = stat.env_wrap;
				state_d      = ST_LEN;
			end
			ST_LEN: begin
				state_d = ST_PER_DEC;
				if (stat.len_en) begin
					cmd.len_dec = 1'b1;
					if (stat.len_expire)
						state_d = ST_DONE;
				end
			end
			ST_PER_DEC: begin
				cmd.per_dec = 1'b1;
				state_d     = ST_PER_WRAP;
			end
			ST_PER_WRAP: begin
				// one duty step per cycle until the counter is positive again
				if (stat.per_wrap)
					cmd.per_step = 1'b1;
				else
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_write_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && s_tvalid && s_tuser == OP_WRITE) |=> (state_q == ST_WRITE))
		else $error("write beat not dispatched to write step");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over an untaken beat");

	a_step_loops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.per_step |=> (state_q == ST_PER_WRAP))
		else $error("duty step left the wrap loop");

endmodule

/* rtl/core/sqch_dp.sv */
// ----------------------------------------------------------------------------
// sqch_dp
// Datapath of the square-wave channel: channel registers, sweep, envelope,
// length and duty counters, mode register and the output register.
// ----------------------------------------------------------------------------
module sqch_dp import sqch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [17:0] in_data,
	input  logic        cfg_valid,
	input  logic        cfg_data,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata,
	input  sqch_cmd_t   cmd,
	output sqch_stat_t  stat
);

	localparam logic [3:0] REG_SWEEP   = 4'd0;
	localparam logic [3:0] REG_DUTY    = 4'd1;
	localparam logic [3:0] REG_ENV     = 4'd2;
	localparam logic [3:0] REG_FREQ_LO = 4'd3;
	localparam logic [3:0] REG_FREQ_HI = 4'd4;

	logic [2:0]       off_q;
	logic [7:0]       data_q;
	logic [CYC_W-1:0] cyc_q;

	logic                   has_sweep_q;
	logic                   run_q;
	logic [FREQ_W-1:0]      freq_q;
	logic [2:0]             sw_code_q;
	logic                   sw_down_q;
	logic [2:0]             sw_shift_q;
	logic [SWEEP_CNT_W-1:0] sw_cnt_q;
	logic [1:0]             duty_sel_q;
	logic [5:0]             len_load_q;
	logic [LEN_CNT_W-1:0]   len_cnt_q;
	logic                   len_en_q;
	logic [3:0]             env_start_q;
	logic [3:0]             env_vol_q;
	logic                   env_up_q;
	logic [2:0]             env_code_q;
	logic [ENV_CNT_W-1:0]   env_cnt_q;
	logic [PER_CNT_W-1:0]   per_cnt_q;
	logic [RELOAD_W-1:0]    reload_q;
	logic [2:0]             duty_pos_q;
	logic [7:0]             rb_q;

	logic       m_valid_q;
	logic [7:0] m_rb_q;
	logic [4:0] m_sample_q;
	logic       m_run_q;

	logic [3:0]           reg_idx;
	logic [FREQ_W-1:0]    hi_freq;
	logic [FREQ_W-1:0]    sw_delta;
	logic [FREQ_W:0]      sw_sum;
	logic [FREQ_W-1:0]    sw_freq_next;
	logic [RELOAD_W-1:0]  sw_reload;
	logic [RELOAD_W-1:0]  hi_reload;
	logic [LEN_CNT_W-1:0] len_diff;
	logic [5:0]           level_high;
	logic [4:0]           level;

	assign reg_idx  = has_sweep_q ? {1'b0, off_q} : {1'b0, off_q} + 4'd1;
	assign hi_freq  = {data_q[2:0], freq_q[7:0]};
	assign hi_reload = period_reload(hi_freq);

	assign sw_delta     = freq_q >> sw_shift_q;
	assign sw_sum       = {1'b0, freq_q} + {1'b0, sw_delta};
	assign sw_freq_next = sw_down_q ? (freq_q - sw_delta) : sw_sum[FREQ_W-1:0];
	assign sw_reload    = period_reload(sw_freq_next);

	assign len_diff = len_cnt_q - LEN_CNT_W'(cyc_q);

	assign stat.running      = run_q;
	assign stat.sweep_active = has_sweep_q && (sw_code_q != 3'd0) && (sw_shift_q != 3'd0);
	assign stat.sweep_wrap   = sw_cnt_q[SWEEP_CNT_W-1] || (sw_cnt_q == '0);
	assign stat.sweep_ovf    = !sw_down_q && sw_sum[FREQ_W];
	assign stat.env_active   = (env_code_q != 3'd0);
	assign stat.env_wrap     = env_cnt_q[ENV_CNT_W-1] || (env_cnt_q == '0);
	assign stat.len_en       = len_en_q;
	assign stat.len_expire   = len_diff[LEN_CNT_W-1] || (len_diff == '0);
	assign stat.per_wrap     = per_cnt_q[PER_CNT_W-1] || (per_cnt_q == '0);
	assign stat.out_free     = !m_valid_q || m_tready;

	// 2*volume - 15 when the step is high
	assign level_high = {1'b0, env_vol_q, 1'b0} - 6'd15;
	always_comb begin
		if (!run_q)
			level = 5'd0;
		else if (duty_high(duty_sel_q, duty_pos_q))
			level = level_high[4:0];
		else
			level = 5'b10001;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			off_q  <= in_data[2:0];
			data_q <= in_data[10:3];
			cyc_q  <= in_data[17:11];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			has_sweep_q <= 1'b1;
		else if (cfg_valid)
			has_sweep_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			freq_q      <= '0;
			sw_code_q   <= '0;
			sw_down_q   <= 1'b0;
			sw_shift_q  <= '0;
			sw_cnt_q    <= '0;
			duty_sel_q  <= '0;
			len_load_q  <= '0;
			len_cnt_q   <= '0;
			len_en_q    <= 1'b0;
			env_start_q <= '0;
			env_vol_q   <= '0;
			env_up_q    <= 1'b0;
			env_code_q  <= '0;
			env_cnt_q   <= '0;
			per_cnt_q   <= '0;
			reload_q    <= RELOAD_W'(16384);
			duty_pos_q  <= '0;
			rb_q        <= '0;
		end else if (cmd.load_in) begin
			rb_q <= '0;
		end else if (cmd.do_write) begin
			case (reg_idx)
				REG_SWEEP: begin
					sw_code_q  <= data_q[6:4];
					sw_down_q  <= data_q[3];
					sw_shift_q <= data_q[2:0];
					sw_cnt_q   <= sweep_period(data_q[6:4]);
					rb_q       <= data_q;
				end
				REG_DUTY: begin
					duty_sel_q <= data_q[7:6];
					len_load_q <= data_q[5:0];
					len_cnt_q  <= length_period(data_q[5:0]);
					rb_q       <= data_q & 8'hC0;
				end
				REG_ENV: begin
					env_start_q <= data_q[7:4];
					env_vol_q   <= data_q[7:4];
					env_up_q    <= data_q[3];
					env_code_q  <= data_q[2:0];
					env_cnt_q   <= env_period(data_q[2:0]);
					rb_q        <= data_q;
				end
				REG_FREQ_LO: begin
					freq_q <= {freq_q[10:8], data_q};
					rb_q   <= '0;
				end
				REG_FREQ_HI: begin
					freq_q   <= hi_freq;
					len_en_q <= data_q[6];
					rb_q     <= data_q & 8'h40;
					// trigger: reload every counter and start sounding
					if (data_q[7]) begin
						sw_cnt_q   <= sweep_period(sw_code_q);
						env_vol_q  <= env_start_q;
						env_cnt_q  <= env_period(env_code_q);
						len_cnt_q  <= length_period(len_load_q);
						reload_q   <= hi_reload;
						per_cnt_q  <= {1'b0, hi_reload};
						duty_pos_q <= '0;
						run_q      <= 1'b1;
					end
				end
				default: begin
					rb_q <= '0;
				end
			endcase
		end else if (cmd.sweep_dec) begin
			sw_cnt_q <= sw_cnt_q - SWEEP_CNT_W'(cyc_q);
		end else if (cmd.sweep_step) begin
			sw_cnt_q <= sw_cnt_q + sweep_period(sw_code_q);
			if (stat.sweep_ovf) begin
				run_q <= 1'b0;
			end else begin
				freq_q     <= sw_freq_next;
				reload_q   <= sw_reload;
				per_cnt_q  <= {1'b0, sw_reload};
				duty_pos_q <= '0;
			end
		end else if (cmd.env_dec) begin
			env_cnt_q <= env_cnt_q - ENV_CNT_W'(cyc_q);
		end else if (cmd.env_step) begin
			env_cnt_q <= env_cnt_q + env_period(env_code_q);
			if (env_up_q) begin
				if (env_vol_q != 4'd15)
					env_vol_q <= env_vol_q + 4'd1;
			end else if (env_vol_q != 4'd0) begin
				env_vol_q <= env_vol_q - 4'd1;
			end
		end else if (cmd.len_dec) begin
			len_cnt_q <= len_diff;
			if (stat.len_expire)
				run_q <= 1'b0;
		end else if (cmd.per_dec) begin
			per_cnt_q <= per_cnt_q - PER_CNT_W'(cyc_q);
		end else if (cmd.per_step) begin
			per_cnt_q  <= per_cnt_q + {1'b0, reload_q};
			duty_pos_q <= duty_pos_q + 3'd1;
		end
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (cmd.out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_rb_q     <= rb_q;
			m_sample_q <= level;
			m_run_q    <= run_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_run_q, m_sample_q, m_rb_q};

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_silent_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !run_q) |=> (m_sample_q == 5'd0 && !m_run_q))
		else $error("stopped channel gave a nonzero sample");

	a_ovf_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_step && stat.sweep_ovf) |=> !run_q)
		else $error("sweep overflow left the channel running");

endmodule

/* rtl/core/square_wave_sound_channel.sv */
// ----------------------------------------------------------------------------
// square_wave_sound_channel
// Square-wave sound channel with frequency sweep, volume envelope, length
// counter and 8-step duty sequencer; one result beat per input beat.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  s_tuser operation, s_tdata fields
//   m_*      out        m_tvalid / m_tready  m_tdata read_back, sample, running
//   cfg_*    in         cfg_valid/cfg_ready  cfg_data has_sweep
//
// A write beat passes through the write step; a tick on a stopped channel goes
// straight to the result. A tick on a running channel walks the active sweep and
// envelope steps, the length step and n duty steps (up to 16), walked one per
// cycle by the period counter loop; a sweep overflow or length expiry ends it early.
// The result sits in an output register, so the next beat is taken while
// it waits; a held result stalls only the end of the following item.
// Reset is asynchronous and sets every channel register to its reset value; no clearing pass.
// ----------------------------------------------------------------------------
module square_wave_sound_channel import sqch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [2:0] reg_offset, [10:3] write_data, [17:11] cycles
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] read_back, [12:8] sample, [13] running
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	sqch_cmd_t  cmd;
	sqch_stat_t stat;

	assign cfg_ready = 1'b1;

	sqch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	sqch_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata[17:0]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* verif/square_wave_sound_channel_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_wave_sound_channel_test
// Self-checking bench for the square-wave channel. Register writes and time
// ticks go in on the input stream. A scoreboard keeps its own copy of the
// channel (sweep, envelope, length and duty counters) and predicts one result
// per accepted input beat, then compares every output beat against it.
// It runs a directed opening, then a long note that reaches sweep overflow,
// then random notes under several idle and stall mixes, with the sweep
// register switched on and off between phases.
// ----------------------------------------------------------------------------
module square_wave_sound_channel_test;
	import sqch_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 8;
	localparam int RUN_LIMIT    = 2_000_000;
	localparam int TAIL_CYCLES  = 32;
	localparam int PHASE_ITEMS  = 40;
	localparam int LONG_HOLD    = 300;
	localparam int MAX_PRINTED  = 40;

	localparam logic [7:0] TRIGGER_BIT   = 8'h80;
	localparam logic [7:0] LENGTH_EN_BIT = 8'h40;
	localparam logic [7:0] DUTY_BITS     = 8'hC0;

	// high steps of each duty pattern, bit i = step i
	localparam logic [3:0][7:0] DUTY_HIGH_STEPS = {8'h7E, 8'hE1, 8'h81, 8'h80};

	typedef enum int {
		REG_SWEEP,
		REG_DUTY_LEN,
		REG_ENVELOPE,
		REG_FREQ_LO,
		REG_FREQ_HI
	} chan_reg_e;

	typedef struct packed {
		logic       op;
		logic [2:0] offset;
		logic [7:0] data;
		logic [6:0] cycles;
	} chan_item_t;

	typedef struct packed {
		logic [7:0] read_back;
		logic [4:0] level;
		logic       running;
	} chan_result_t;

	class tone_scoreboard;
		chan_result_t expected_q[$];
		int           mismatches;
		int           results_seen;

		bit          sweep_present;
		bit          sounding;
		logic [10:0] freq;
		logic [2:0]  sweep_code;
		bit          sweep_down;
		logic [2:0]  sweep_shift;
		int          sweep_cnt;
		logic [1:0]  duty_sel;
		logic [5:0]  len_load;
		int          len_cnt;
		bit          len_en;
		logic [3:0]  env_start;
		logic [3:0]  env_vol;
		bit          env_up;
		logic [2:0]  env_code;
		int          env_cnt;
		int          step_cnt;
		int          step_reload;
		logic [2:0]  duty_pos;

		function new();
			mismatches = 0;
			results_seen = 0;
			sweep_present = 1'b1;
			sounding = 1'b0;
			freq = '0;
			sweep_code = '0;
			sweep_down = 1'b0;
			sweep_shift = '0;
			sweep_cnt = 0;
			duty_sel = '0;
			len_load = '0;
			len_cnt = 0;
			len_en = 1'b0;
			env_start = '0;
			env_vol = '0;
			env_up = 1'b0;
			env_code = '0;
			env_cnt = 0;
			step_cnt = 0;
			step_reload = 16384;
			duty_pos = '0;
		endfunction

		function void load_frequency();
			step_reload = 8 * (2048 - int'(freq));
			step_cnt = step_reload;
			duty_pos = '0;
		endfunction

		function void note_input(chan_item_t it);
			chan_result_t want;
			int reg_sel;
			int next_freq;
			int lvl;
			want.read_back = '0;
			if (it.op == OP_WRITE) begin
				// without the sweep register, offsets start at the duty/length register
				reg_sel = sweep_present ? int'(it.offset) : int'(it.offset) + 1;
				case (reg_sel)
					REG_SWEEP: begin
						sweep_code = it.data[6:4];
						sweep_down = it.data[3];
						sweep_shift = it.data[2:0];
						sweep_cnt = int'(sweep_code) * SWEEP_UNIT_CYCLES;
						want.read_back = it.data;
					end
					REG_DUTY_LEN: begin
						duty_sel = it.data[7:6];
						len_load = it.data[5:0];
						len_cnt = (64 - int'(len_load)) * LENGTH_UNIT_CYCLES;
						want.read_back = it.data & DUTY_BITS;
					end
					REG_ENVELOPE: begin
						env_start = it.data[7:4];
						env_vol = env_start;
						env_up = it.data[3];
						env_code = it.data[2:0];
						env_cnt = int'(env_code) * ENVELOPE_UNIT_CYCLES;
						want.read_back = it.data;
					end
					REG_FREQ_LO: begin
						freq[7:0] = it.data;
					end
					REG_FREQ_HI: begin
						freq[10:8] = it.data[2:0];
						len_en = it.data[6];
						if ((it.data & TRIGGER_BIT) != 0) begin
							sweep_cnt = int'(sweep_code) * SWEEP_UNIT_CYCLES;
							env_vol = env_start;
							env_cnt = int'(env_code) * ENVELOPE_UNIT_CYCLES;
							len_cnt = (64 - int'(len_load)) * LENGTH_UNIT_CYCLES;
							load_frequency();
							sounding = 1'b1;
						end
						want.read_back = it.data & LENGTH_EN_BIT;
					end
					default: ;
				endcase
			end else if (sounding) begin
				if (sweep_present && sweep_code != 0 && sweep_shift != 0) begin
					sweep_cnt -= int'(it.cycles);
					while (sounding && sweep_cnt <= 0) begin
						sweep_cnt += int'(sweep_code) * SWEEP_UNIT_CYCLES;
						if (sweep_down)
							next_freq = int'(freq) - int'(freq >> sweep_shift);
						else
							next_freq = int'(freq) + int'(freq >> sweep_shift);
						if (next_freq >= 2048) begin
							// overflow: silence the channel, rest of the tick is skipped
							sounding = 1'b0;
						end else begin
							freq = 11'(next_freq);
							load_frequency();
						end
					end
				end
				if (sounding && env_code != 0) begin
					env_cnt -= int'(it.cycles);
					while (env_cnt <= 0) begin
						env_cnt += int'(env_code) * ENVELOPE_UNIT_CYCLES;
						if (env_up) begin
							if (env_vol != 4'd15)
								env_vol++;
						end else if (env_vol != 4'd0) begin
							env_vol--;
						end
					end
				end
				if (sounding && len_en) begin
					len_cnt -= int'(it.cycles);
					if (len_cnt <= 0)
						sounding = 1'b0;
				end
				if (sounding) begin
					step_cnt -= int'(it.cycles);
					while (step_cnt <= 0) begin
						step_cnt += step_reload;
						duty_pos++;
					end
				end
			end
			lvl = 0;
			if (sounding)
				lvl = DUTY_HIGH_STEPS[duty_sel][duty_pos] ? 2 * int'(env_vol) - 15 : -15;
			want.level = 5'(lvl);
			want.running = sounding;
			expected_q.push_back(want);
		endfunction

		task report(string msg);
			// keep the log short when things go badly wrong
			if (mismatches < MAX_PRINTED)
				$display("ERROR: %s", msg);
			mismatches++;
		endtask

		task check_result(logic [15:0] beat);
			chan_result_t want;
			chan_result_t got;
			got.read_back = beat[7:0];
			got.level = beat[12:8];
			got.running = beat[13];
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat %0d (%h) arrived with nothing pending",
					results_seen, beat));
				return;
			end
			want = expected_q.pop_front();
			if (got.read_back != want.read_back)
				report($sformatf("beat %0d read_back: expected %h, got %h", results_seen,
					want.read_back, got.read_back));
			if (got.level != want.level)
				report($sformatf("beat %0d sample: expected %0d, got %0d", results_seen,
					$signed(want.level), $signed(got.level)));
			if (got.running != want.running)
				report($sformatf("beat %0d running: expected %0b, got %0b", results_seen,
					want.running, got.running));
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;    // [2:0] reg_offset, [10:3] write_data, [17:11] cycles
	logic        s_tuser = 1'b0;  // [0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [7:0] read_back, [12:8] sample, [13] running
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	tone_scoreboard score;

	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	bit          sweep_reg_present = 1'b1;
	int unsigned cycle_count = 0;

	square_wave_sound_channel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: check each beat, then decide the next cycle's tready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				score.check_result(m_tdata);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic send_item(logic op, logic [2:0] offset, logic [7:0] data, logic [6:0] cyc);
		chan_item_t it;
		it.op = op;
		it.offset = offset;
		it.data = data;
		it.cycles = cyc;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, cyc, data, offset};
		do @(posedge clk); while (!s_tready);
		score.note_input(it);
		items_sent++;
	endtask

	task automatic tick_item(logic [6:0] cyc);
		send_item(OP_TICK, 3'($urandom_range(4)), 8'($urandom_range(255)), cyc);
	endtask

	task automatic write_reg(chan_reg_e r, logic [7:0] v);
		if (!sweep_reg_present && r == REG_SWEEP)
			return;
		send_item(OP_WRITE, sweep_reg_present ? 3'(int'(r)) : 3'(int'(r) - 1), v,
			7'($urandom_range(64)));
	endtask

	// drop valid and hold until every pending result is back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (score.expected_q.size() != 0);
	endtask

	// only while idle; the channel has a single configuration bit, has_sweep
	task automatic set_sweep_present(bit v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		score.sweep_present = v;
		sweep_reg_present = v;
	endtask

	task automatic start_note(logic [7:0] sweep, logic [7:0] duty_len, logic [7:0] env,
			logic [10:0] f, bit len_on);
		write_reg(REG_SWEEP, sweep);
		write_reg(REG_DUTY_LEN, duty_len);
		write_reg(REG_ENVELOPE, env);
		write_reg(REG_FREQ_LO, f[7:0]);
		write_reg(REG_FREQ_HI, {1'b1, len_on, 3'($urandom_range(7)), f[10:8]});
	endtask

	task automatic play_note(int n_ticks);
		logic [10:0] f;
		int pick;
		// favor high pitches so the duty sequencer moves within a few ticks
		f = $urandom_range(1) ? 11'($urandom_range(1800, 2047)) : 11'($urandom_range(2047));
		start_note(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			f, 1'($urandom_range(1)));
		repeat (n_ticks) begin
			pick = $urandom_range(99);
			if (pick < 8)
				write_reg(chan_reg_e'($urandom_range(4)), 8'($urandom_range(255)));
			else if (pick < 12)
				send_item(1'($urandom_range(1)), 3'($urandom_range(4)),
					8'($urandom_range(255)), 7'($urandom_range(64)));
			else if (pick < 80)
				tick_item(7'($urandom_range(32, 64)));
			else
				tick_item(7'($urandom_range(64)));
		end
	endtask

	task automatic random_notes(int n);
		int first;
		first = items_sent;
		while (items_sent - first < n / 2)
			play_note($urandom_range(4, 40));
		// back up the block against a blocked result side
		hold_request = LONG_HOLD;
		play_note(30);
		wait_drain();
		while (items_sent - first < n)
			play_note($urandom_range(4, 40));
	endtask

	initial begin
		score = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, sweep register present
		tick_item(7'd64);
		write_reg(REG_SWEEP, 8'h00);
		write_reg(REG_SWEEP, 8'hFF);
		write_reg(REG_DUTY_LEN, 8'hFF);
		write_reg(REG_ENVELOPE, 8'hF0);
		write_reg(REG_FREQ_LO, 8'hFF);
		write_reg(REG_FREQ_HI, 8'hC7);
		tick_item(7'd0);
		tick_item(7'd1);
		tick_item(7'd64);
		tick_item(7'd63);
		tick_item(7'd8);
		write_reg(REG_ENVELOPE, 8'h3F);
		write_reg(REG_DUTY_LEN, 8'h40);
		tick_item(7'd64);
		write_reg(REG_FREQ_HI, 8'h47);
		write_reg(REG_FREQ_LO, 8'h00);
		write_reg(REG_FREQ_HI, 8'h80);
		tick_item(7'd64);
		write_reg(REG_SWEEP, 8'h80);
		write_reg(REG_DUTY_LEN, 8'h80);
		tick_item(7'd64);
		wait_drain();
		set_sweep_present(1'b0);
		send_item(OP_WRITE, 3'd4, 8'hFF, 7'd0);
		send_item(OP_WRITE, 3'd0, 8'hBF, 7'd0);
		tick_item(7'd64);

		// no idling; upward sweep that overflows on its first step
		wait_drain();
		set_sweep_present(1'b1);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		start_note({1'b0, 3'd1, 1'b0, 3'($urandom_range(1, 2))}, 8'($urandom_range(255)),
			8'($urandom_range(255)), 11'($urandom_range(1700, 2047)), 1'b0);
		// 1024 full ticks run the sweep counter down to zero
		repeat (1030) tick_item(7'd64);
		random_notes(PHASE_ITEMS);

		// sender idles half the time, no sweep register
		wait_drain();
		set_sweep_present(1'b0);
		src_idle_pct = 50;
		sink_stall_pct = 0;
		random_notes(PHASE_ITEMS);

		// receiver stalls half the time
		wait_drain();
		set_sweep_present(1'b1);
		src_idle_pct = 0;
		sink_stall_pct = 50;
		random_notes(PHASE_ITEMS);

		// both sides idle
		wait_drain();
		set_sweep_present(1'b0);
		src_idle_pct = 22;
		sink_stall_pct = 22;
		random_notes(PHASE_ITEMS);

		wait_drain();
		// watch for stray beats after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (score.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
rtl/core/sqch_pkg.sv
rtl/core/sqch_ctrl.sv
rtl/core/sqch_dp.sv
rtl/core/square_wave_sound_channel.sv
verif/square_wave_sound_channel_test.sv
